FILE: hw/rtl/eld_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eld_pkg: shared types and tables for the ECG packet lead deriver
// Device modes, channel operations, controller/datapath command and status
// structs, and the per-mode channel tables.
// ----------------------------------------------------------------------------
package eld_pkg;

	typedef enum logic [1:0] {
		MODE_NONE,
		MODE_TEST,
		MODE_OXI,
		MODE_ECG
	} mode_t;

	typedef enum logic [2:0] {
		OP_RAW1,
		OP_RAW3,
		OP_III,
		OP_AVR,
		OP_AVL,
		OP_AVF
	} op_t;

	// Byte offsets used by the channel tables all fit in five bits
	localparam int unsigned OFS_W = 5;

	localparam logic [3:0] CH_I   = 4'd0;
	localparam logic [3:0] CH_II  = 4'd1;
	localparam logic [3:0] CH_III = 4'd2;
	localparam logic [3:0] CH_AVR = 4'd3;
	localparam logic [3:0] CH_AVL = 4'd4;
	localparam logic [3:0] CH_AVF = 4'd5;
	localparam logic [3:0] CH_V1  = 4'd6;
	localparam logic [3:0] CH_V2  = 4'd7;
	localparam logic [3:0] CH_V3  = 4'd8;
	localparam logic [3:0] CH_V4  = 4'd9;
	localparam logic [3:0] CH_V5  = 4'd10;
	localparam logic [3:0] CH_V6  = 4'd11;

	localparam logic [OFS_W-1:0] TEST_MIN_BYTES = 5'd2;
	localparam logic [OFS_W-1:0] OXI_MIN_BYTES  = 5'd6;
	localparam logic [OFS_W-1:0] ECG_MIN_BYTES  = 5'd27;

	typedef struct packed {
		logic             fill_rdy;
		logic             rd_en;
		logic             rd_first;
		logic [OFS_W-1:0] rd_addr;
		logic             emit;
		op_t              op;
		logic [3:0]       channel;
		logic             last;
		logic             err;
	} dp_cmd_t;

	typedef struct packed {
		logic  eop_taken;
		logic  out_free;
		logic  short_pkt;
		mode_t mode;
	} dp_sts_t;

	function automatic op_t chan_op(input mode_t m, input logic [3:0] k);
		op_t op;
		op = OP_RAW3;
		unique case (m)
			MODE_TEST: op = OP_RAW1;
			MODE_ECG: begin
				unique case (k)
					CH_III:  op = OP_III;
					CH_AVR:  op = OP_AVR;
					CH_AVL:  op = OP_AVL;
					CH_AVF:  op = OP_AVF;
					default: op = OP_RAW3;
				endcase
			end
			default: op = OP_RAW3;
		endcase
		return op;
	endfunction

	function automatic logic [OFS_W-1:0] chan_base(input mode_t m, input logic [3:0] k);
		logic [OFS_W-1:0] b;
		b = '0;
		unique case (m)
			MODE_TEST: b = {1'b0, k};
			MODE_OXI:  b = (k == CH_I) ? 5'd0 : 5'd3;
			MODE_ECG: begin
				unique case (k)
					CH_I:    b = 5'd6;
					CH_II:   b = 5'd9;
					CH_V1:   b = 5'd24;
					CH_V2:   b = 5'd12;
					CH_V3:   b = 5'd15;
					CH_V4:   b = 5'd18;
					CH_V5:   b = 5'd21;
					CH_V6:   b = 5'd3;
					default: b = 5'd0;
				endcase
			end
			default: b = '0;
		endcase
		return b;
	endfunction

	function automatic logic [3:0] last_chan(input mode_t m);
		return (m == MODE_ECG) ? CH_V6 : CH_II;
	endfunction

	function automatic logic [OFS_W-1:0] min_bytes(input mode_t m);
		logic [OFS_W-1:0] n;
		unique case (m)
			MODE_TEST: n = TEST_MIN_BYTES;
			MODE_OXI:  n = OXI_MIN_BYTES;
			MODE_ECG:  n = ECG_MIN_BYTES;
			default:   n = '0;
		endcase
		return n;
	endfunction

endpackage

FILE: hw/rtl/eld_byte_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eld_byte_if: packet byte channel
// One packet byte per transaction with an end-of-packet mark.
// ----------------------------------------------------------------------------
interface eld_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_packet;

	modport source (output valid, data_byte, end_of_packet, input ready);
	modport sink (input valid, data_byte, end_of_packet, output ready);
endinterface

FILE: hw/rtl/eld_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eld_result_if: result channel
// One channel sample per transaction, with status and last mark.
// ----------------------------------------------------------------------------
interface eld_result_if;
	logic               valid;
	logic               ready;
	logic [3:0]         channel;
	logic signed [24:0] sample;
	logic               status;
	logic               last;

	modport source (output valid, channel, sample, status, last, input ready);
	modport sink (input valid, channel, sample, status, last, output ready);
endinterface

FILE: hw/rtl/eld_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eld_cfg_if: configuration write channel
// Carries the device mode register write data.
// ----------------------------------------------------------------------------
interface eld_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] device_mode;

	modport source (output valid, device_mode, input ready);
	modport sink (input valid, device_mode, output ready);
endinterface

FILE: hw/rtl/eld_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eld_ctrl: packet sequencer
// Fills the store, checks its length, then walks the channels of the mode,
// issuing byte reads and result emits to the datapath, or one error result.
// ----------------------------------------------------------------------------
module eld_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  eld_pkg::dp_sts_t sts,
	output eld_pkg::dp_cmd_t cmd
);
	import eld_pkg::*;

	typedef enum logic [2:0] {
		S_FILL,
		S_CHECK,
		S_READ,
		S_EMIT,
		S_ERR
	} state_t;

	state_t     state_q;
	logic [3:0] k_q;
	logic [1:0] byte_q;

	op_t        op_cur;
	op_t        op_nxt;
	logic [3:0] k_nxt;
	logic       rd_done;
	logic       at_last;

	always_comb begin
		k_nxt   = k_q + 4'd1;
		op_cur  = chan_op(sts.mode, k_q);
		op_nxt  = chan_op(sts.mode, k_nxt);
		rd_done = (op_cur == OP_RAW1) || (byte_q == 2'd2);
		at_last = (k_q == last_chan(sts.mode));
	end

	always_comb begin
		cmd          = '0;
		cmd.fill_rdy = (state_q == S_FILL);
		cmd.rd_en    = (state_q == S_READ);
		cmd.rd_first = (byte_q == 2'd0);
		cmd.rd_addr  = chan_base(sts.mode, k_q) + {3'b000, byte_q};
		cmd.emit     = ((state_q == S_EMIT) || (state_q == S_ERR)) && sts.out_free;
		cmd.op       = op_cur;
		cmd.err      = (state_q == S_ERR);
		cmd.channel  = (state_q == S_ERR) ? CH_I : k_q;
		cmd.last     = (state_q == S_ERR) || at_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_FILL;
			k_q     <= '0;
			byte_q  <= '0;
		end else begin
			unique case (state_q)
				S_FILL: begin
					if (sts.eop_taken) state_q <= S_CHECK;
				end
				S_CHECK: begin
					k_q    <= '0;
					byte_q <= '0;
					if (sts.mode == MODE_NONE) state_q <= S_FILL;
					else if (sts.short_pkt) state_q <= S_ERR;
					else state_q <= S_READ;
				end
				S_READ: begin
					if (rd_done) begin
						byte_q  <= '0;
						state_q <= S_EMIT;
					end else begin
						byte_q <= byte_q + 2'd1;
					end
				end
				S_EMIT: begin
					if (sts.out_free) begin
						if (at_last) begin
							state_q <= S_FILL;
						end else begin
							k_q <= k_nxt;
							if (op_nxt == OP_RAW1 || op_nxt == OP_RAW3) state_q <= S_READ;
							else state_q <= S_EMIT;
						end
					end
				end
				S_ERR: begin
					if (sts.out_free) state_q <= S_FILL;
				end
				default: state_q <= S_FILL;
			endcase
		end
	end

endmodule

FILE: hw/rtl/eld_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eld_datapath: packet store, lead assembly and result register
// Holds the mode register, the byte store with its count, the 24-bit
// assembly register, leads I and II, and the output register.
// ----------------------------------------------------------------------------
module eld_datapath #(
	parameter int unsigned PACKET_BYTES = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  eld_pkg::dp_cmd_t   cmd,
	output eld_pkg::dp_sts_t   sts,
	input  logic               cfg_valid,
	input  logic [1:0]         cfg_mode,
	input  logic               pkt_valid,
	input  logic [7:0]         pkt_byte,
	input  logic               pkt_eop,
	output logic               res_valid,
	input  logic               res_ready,
	output logic [3:0]         res_channel,
	output logic signed [24:0] res_sample,
	output logic               res_status,
	output logic               res_last
);
	import eld_pkg::*;

	localparam int unsigned AW = $clog2(PACKET_BYTES);
	localparam int unsigned CW = $clog2(PACKET_BYTES + 1);

	logic [7:0]  store_q [PACKET_BYTES];
	logic [CW-1:0] count_q;
	logic [CW-1:0] len_q;
	logic [CW-1:0] count_nxt;
	logic          has_room;
	logic          take;
	mode_t         mode_q;

	logic [23:0] acc_q;
	logic [23:0] lead_i_q;
	logic [23:0] lead_ii_q;
	logic [24:0] lead_sum;
	logic [24:0] sample_nxt;
	logic        out_free;

	assign take      = pkt_valid && cmd.fill_rdy;
	assign has_room  = (count_q < CW'(PACKET_BYTES));
	assign count_nxt = has_room ? count_q + CW'(1) : count_q;
	assign out_free  = !res_valid || res_ready;

	always_comb begin
		sts.eop_taken = take && pkt_eop;
		sts.out_free  = out_free;
		sts.short_pkt = (len_q < CW'(min_bytes(mode_q)));
		sts.mode      = mode_q;
	end

	// Store write; bytes beyond the store are dropped
	always_ff @(posedge clk) begin
		if (take && has_room) store_q[count_q[AW-1:0]] <= pkt_byte;
	end

	// Byte read into the assembly register, big-endian
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			if (cmd.rd_first) acc_q <= {16'h0000, store_q[AW'(cmd.rd_addr)]};
			else acc_q <= {acc_q[15:0], store_q[AW'(cmd.rd_addr)]};
		end
		if (cmd.emit && !cmd.err && cmd.channel == CH_I) lead_i_q <= acc_q;
		if (cmd.emit && !cmd.err && cmd.channel == CH_II) lead_ii_q <= acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_NONE;
			count_q <= '0;
			len_q   <= '0;
		end else begin
			if (cfg_valid) mode_q <= mode_t'(cfg_mode);
			if (take) begin
				if (pkt_eop) begin
					len_q   <= count_nxt;
					count_q <= '0;
				end else begin
					count_q <= count_nxt;
				end
			end
		end
	end

	// Derived leads: leads are non-negative, so halving is a right shift
	always_comb begin
		lead_sum = {1'b0, lead_i_q} + {1'b0, lead_ii_q};
		unique case (cmd.op)
			OP_III:  sample_nxt = {1'b0, lead_ii_q} - {1'b0, lead_i_q};
			OP_AVR:  sample_nxt = 25'd0 - {1'b0, lead_sum[24:1]};
			OP_AVL:  sample_nxt = {1'b0, lead_i_q} - {2'b00, lead_ii_q[23:1]};
			OP_AVF:  sample_nxt = {1'b0, lead_ii_q} - {2'b00, lead_i_q[23:1]};
			default: sample_nxt = {1'b0, acc_q};
		endcase
		if (cmd.err) sample_nxt = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else begin
			if (cmd.emit) res_valid <= 1'b1;
			else if (res_ready) res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_channel <= cmd.channel;
			res_sample  <= $signed(sample_nxt);
			res_status  <= cmd.err;
			res_last    <= cmd.last;
		end
	end

endmodule

FILE: hw/rtl/ecg_packet_lead_deriver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecg_packet_lead_deriver: ECG device packet unpacker and lead deriver
// Collects a device packet byte by byte and, at its end, emits the channel
// samples for the configured device mode (test, oximeter, twelve-lead ECG).
// ----------------------------------------------------------------------------
//
//  Channel  Role        Payload                              Handshake
//  -------  ----------  -----------------------------------  -----------
//  pkt      sink        data_byte[7:0], end_of_packet        valid/ready
//  res      source      channel[3:0], sample[24:0] signed,   valid/ready
//                       status, last
//  cfg      sink        device_mode[1:0]                     valid/ready
//
//  Bytes are taken one per cycle while the packet fills. After the byte with
//  the end mark, pkt.ready drops while the channels are produced: the length
//  is checked, then each stored channel is read a byte at a time (one byte
//  for a test channel, three for a stored 24-bit channel) and emitted, and
//  each derived ECG lead is emitted with no read. The packet store has a
//  single read port, one byte a cycle.
//  A result waiting in the output register stalls only the next emit; the
//  final result may wait while the next packet fills.
//  arst_n clears the mode register (to none), the byte count and the
//  sequencer; the packet store holds no reset. cfg.ready is always high.
//
module ecg_packet_lead_deriver #(
	parameter int unsigned PACKET_BYTES = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	eld_byte_if.sink     pkt,
	eld_result_if.source res,
	eld_cfg_if.sink      cfg
);
	import eld_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// The user must write the mode only while idle; the block does not enforce this
	assign cfg.ready = 1'b1;
	// Take packet bytes only while the sequencer is filling
	assign pkt.ready = cmd.fill_rdy;

	eld_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	eld_datapath #(
		.PACKET_BYTES (PACKET_BYTES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_valid   (cfg.valid),
		.cfg_mode    (cfg.device_mode),
		.pkt_valid   (pkt.valid),
		.pkt_byte    (pkt.data_byte),
		.pkt_eop     (pkt.end_of_packet),
		.res_valid   (res.valid),
		.res_ready   (res.ready),
		.res_channel (res.channel),
		.res_sample  (res.sample),
		.res_status  (res.status),
		.res_last    (res.last)
	);

endmodule

FILE: hw/rtl/eld_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eld_checker: port-level checks for the lead deriver
// Watches the top-level channels and flags ordering and payload slips.
// ----------------------------------------------------------------------------
module eld_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               pkt_valid,
	input logic               pkt_ready,
	input logic               pkt_eop,
	input logic               res_valid,
	input logic               res_ready,
	input logic [3:0]         res_channel,
	input logic signed [24:0] res_sample,
	input logic               res_status,
	input logic               res_last
);
	import eld_pkg::*;

	// Packet end stops intake while the channels are produced
	a_eop_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(pkt_valid && pkt_ready && pkt_eop) |=> !pkt_ready)
		else $error("byte intake not held after end of packet");

	// Error result is alone: channel zero, zero sample, last
	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_status) |-> (res_last && res_channel == CH_I && res_sample == 0))
		else $error("malformed short-packet result");

	// Channel index stays within the twelve leads
	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_channel <= CH_V6))
		else $error("channel index out of range");

	// Stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=>
			(res_valid && $stable(res_channel) && $stable(res_sample) && $stable(res_last)))
		else $error("stalled result changed");

endmodule

bind ecg_packet_lead_deriver eld_checker u_eld_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.pkt_valid   (pkt.valid),
	.pkt_ready   (pkt.ready),
	.pkt_eop     (pkt.end_of_packet),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.res_channel (res.channel),
	.res_sample  (res.sample),
	.res_status  (res.status),
	.res_last    (res.last)
);
